>>> hw/rtl/tmeq_pkg.sv
// ----------------------------------------------------------------------------
// tmeq_pkg: shared types and constants of the timed MIDI event queue
// Defines the queue entry, the per-cell control and the MIDI status codes.
// ----------------------------------------------------------------------------
`default_nettype none
package tmeq_pkg;

   localparam int TIME_W      = 48;
   localparam int OFFSET_W    = 16;
   localparam int MAX_RESULTS = 32;
   localparam int EMIT_W      = 6;

   localparam logic [1:0] OP_SCHEDULE = 2'd0;
   localparam logic [1:0] OP_FLUSH    = 2'd1;
   localparam logic [1:0] OP_CLEAR    = 2'd2;

   localparam logic [3:0]  STATUS_OFF  = 4'h8;
   localparam logic [3:0]  STATUS_ON   = 4'h9;
   localparam logic [3:0]  STATUS_BEND = 4'hE;
   localparam logic [13:0] BEND_CENTRE = 14'd8192;

   typedef struct packed {
      logic [TIME_W-1:0] time_stamp;
      logic [7:0]        status;
      logic [6:0]        data_one;
      logic [6:0]        data_two;
   } entry_type;

   typedef struct packed {
      logic shift;
      logic load;
   } cell_ctrl_type;

endpackage
`default_nettype wire

>>> hw/rtl/tmeq_cell.sv
// ----------------------------------------------------------------------------
// tmeq_cell: one slot of the event chain
// Holds one entry; takes its upper neighbor on a shift or a new entry on load.
// ----------------------------------------------------------------------------
`default_nettype none
module tmeq_cell
   import tmeq_pkg::*;
(
   input  wire logic          clock,
   input  wire cell_ctrl_type ctrl,
   input  wire entry_type     nbr_entry,
   input  wire entry_type     ins_entry,
   output entry_type          entry
);

   entry_type entry_ff;
   entry_type entry_in;

   // choose insert, neighbor or hold
   always_comb begin
      if (ctrl.load) begin
         entry_in = ins_entry;
      end else if (ctrl.shift) begin
         entry_in = nbr_entry;
      end else begin
         entry_in = entry_ff;
      end
   end

   always_ff @(posedge clock) begin
      entry_ff <= entry_in;
   end

   assign entry = entry_ff;

endmodule
`default_nettype wire

>>> hw/rtl/timed_midi_event_queue.sv
// ----------------------------------------------------------------------------
// timed_midi_event_queue: bounded list of time-stamped MIDI messages
// Schedules note/bend messages and flushes them per audio block window.
// ----------------------------------------------------------------------------
// Usage:
//   req_* carries one command per transfer (schedule, flush, clear); rsp_*
//   returns the messages of a flush, one per transfer, the final one flagged
//   by rsp_last. An empty flush returns one transfer with rsp_has_event low.
//   Entries live in a chain of QUEUE_DEPTH cells. A schedule appends two or
//   four messages, one per cycle. A clear empties the queue. A flush walks
//   the chain from its head, one entry per cycle, re-inserting kept entries
//   behind the unvisited ones. The walk pauses while the output register
//   holds an untaken result and another match waits to leave. req_ready is
//   high only between commands. Reset empties the queue and drops any result
//   in flight. A stalled receiver holds rsp_* unchanged.
// ----------------------------------------------------------------------------
`default_nettype none
module timed_midi_event_queue
   import tmeq_pkg::*;
#(
   parameter int QUEUE_DEPTH = 32
)
(
   input  wire logic                clock,
   input  wire logic                reset,
   input  wire logic                req_valid,
   output logic                     req_ready,
   input  wire logic [1:0]          req_opcode,
   input  wire logic [TIME_W-1:0]   req_note_on_time,
   input  wire logic [TIME_W-1:0]   req_note_off_time,
   input  wire logic [4:0]          req_channel,
   input  wire logic [6:0]          req_note,
   input  wire logic [6:0]          req_velocity,
   input  wire logic [13:0]         req_bend_value,
   input  wire logic [15:0]         req_bend_hold,
   input  wire logic [TIME_W-1:0]   req_block_start,
   input  wire logic [OFFSET_W-1:0] req_block_length,
   output logic                     rsp_valid,
   input  wire logic                rsp_ready,
   output logic [7:0]               rsp_status_byte,
   output logic [6:0]               rsp_data_one,
   output logic [6:0]               rsp_data_two,
   output logic [OFFSET_W-1:0]      rsp_sample_offset,
   output logic                     rsp_has_event,
   output logic                     rsp_last
);

   localparam int CW = $clog2(QUEUE_DEPTH + 1);
   localparam logic [CW-1:0] DEPTH_C = CW'(QUEUE_DEPTH);

   localparam logic [1:0] ST_IDLE   = 2'd0;
   localparam logic [1:0] ST_SCHED  = 2'd1;
   localparam logic [1:0] ST_FLUSH  = 2'd2;
   localparam logic [1:0] ST_FINISH = 2'd3;

   localparam logic [1:0] STEP_BEND   = 2'd0;
   localparam logic [1:0] STEP_RETURN = 2'd1;
   localparam logic [1:0] STEP_ON     = 2'd2;
   localparam logic [1:0] STEP_OFF    = 2'd3;

   // control state
   logic [1:0]        state_ff, state_in;
   logic [1:0]        step_ff, step_in;
   logic [CW-1:0]     count_ff, count_in;
   logic [CW-1:0]     unvisited_ff, unvisited_in;
   logic [CW-1:0]     kept_ff, kept_in;
   logic [EMIT_W-1:0] emitted_ff, emitted_in;
   logic              pend_valid_ff, pend_valid_in;
   logic              rsp_valid_ff, rsp_valid_in;

   // payload registers
   logic [TIME_W-1:0]   on_time_ff, off_time_ff, start_ff;
   logic [3:0]          chan_ff;
   logic [6:0]          note_ff, vel_ff;
   logic [13:0]         bend_ff;
   logic [15:0]         hold_ff;
   logic [OFFSET_W-1:0] len_ff;
   entry_type           pend_ff;
   logic [OFFSET_W-1:0] pend_off_ff;
   entry_type           out_ff;
   logic [OFFSET_W-1:0] out_off_ff;
   logic                out_has_ff, out_last_ff;

   logic                accept;
   logic                out_free;
   logic [3:0]          chan_nib;
   entry_type           sched_entry;
   entry_type           head;
   logic [TIME_W-1:0]   head_off;
   logic                head_match;
   logic                walk_step;
   logic                append;
   logic                do_shift;
   logic                do_insert;
   logic [CW-1:0]       insert_pos;
   logic                load_out;
   logic                load_pend;
   entry_type           cell_q [QUEUE_DEPTH];

   assign accept   = req_valid && req_ready;
   assign out_free = !rsp_valid_ff || rsp_ready;

   // saturate the channel into a status nibble
   always_comb begin
      if (req_channel == 5'd0) begin
         chan_nib = 4'd0;
      end else if (req_channel > 5'd16) begin
         chan_nib = 4'd15;
      end else begin
         chan_nib = 4'(req_channel - 5'd1);
      end
   end

   // build the message of the current schedule step
   always_comb begin
      case (step_ff)
         STEP_BEND: begin
            sched_entry = '{on_time_ff, {STATUS_BEND, chan_ff}, bend_ff[6:0], bend_ff[13:7]};
         end
         STEP_RETURN: begin
            sched_entry = '{on_time_ff + TIME_W'(hold_ff), {STATUS_BEND, chan_ff},
                            BEND_CENTRE[6:0], BEND_CENTRE[13:7]};
         end
         STEP_ON: begin
            sched_entry = '{on_time_ff, {STATUS_ON, chan_ff}, note_ff, vel_ff};
         end
         default: begin
            sched_entry = '{off_time_ff, {STATUS_OFF, chan_ff}, note_ff, 7'd0};
         end
      endcase
   end

   // test the chain head against the window
   assign head       = cell_q[0];
   assign head_off   = head.time_stamp - start_ff;
   assign head_match = (head_off < TIME_W'(len_ff)) &&
                       (emitted_ff < EMIT_W'(MAX_RESULTS));
   assign walk_step  = (state_ff == ST_FLUSH) &&
                       (!head_match || !pend_valid_ff || out_free);
   assign append     = (state_ff == ST_SCHED) && (count_ff < DEPTH_C);
   assign do_shift   = walk_step;
   assign do_insert  = walk_step && !head_match;
   assign insert_pos = append ? count_ff : (unvisited_ff - 1'b1 + kept_ff);

   // chain of cells
   for (genvar i = 0; i < QUEUE_DEPTH; i++) begin : g_cell
      cell_ctrl_type ctrl;
      entry_type     nbr;
      assign ctrl.shift = do_shift;
      assign ctrl.load  = (append || do_insert) && (insert_pos == CW'(i));
      if (i == QUEUE_DEPTH - 1) begin : g_top
         assign nbr = cell_q[i];
      end else begin : g_mid
         assign nbr = cell_q[i+1];
      end
      tmeq_cell u_cell (
         .clock     (clock),
         .ctrl      (ctrl),
         .nbr_entry (nbr),
         .ins_entry (append ? sched_entry : head),
         .entry     (cell_q[i])
      );
   end

   // sequence commands
   always_comb begin
      state_in      = state_ff;
      step_in       = step_ff;
      count_in      = count_ff;
      unvisited_in  = unvisited_ff;
      kept_in       = kept_ff;
      emitted_in    = emitted_ff;
      pend_valid_in = pend_valid_ff;
      load_out      = 1'b0;
      load_pend     = 1'b0;
      case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               case (req_opcode)
                  OP_SCHEDULE: begin
                     state_in = ST_SCHED;
                     step_in  = (req_bend_value != BEND_CENTRE) ? STEP_BEND : STEP_ON;
                  end
                  OP_FLUSH: begin
                     state_in      = (count_ff == '0) ? ST_FINISH : ST_FLUSH;
                     unvisited_in  = count_ff;
                     kept_in       = '0;
                     emitted_in    = '0;
                     pend_valid_in = 1'b0;
                  end
                  OP_CLEAR: begin
                     count_in = '0;
                  end
                  default: begin
                     state_in = ST_IDLE;
                  end
               endcase
            end
         end
         ST_SCHED: begin
            if (append) begin
               count_in = count_ff + 1'b1;
            end
            step_in = step_ff + 2'd1;
            if (step_ff == STEP_OFF) begin
               state_in = ST_IDLE;
            end
         end
         ST_FLUSH: begin
            if (walk_step) begin
               unvisited_in = unvisited_ff - 1'b1;
               if (head_match) begin
                  load_out      = pend_valid_ff;
                  load_pend     = 1'b1;
                  pend_valid_in = 1'b1;
                  emitted_in    = emitted_ff + 1'b1;
               end else begin
                  kept_in = kept_ff + 1'b1;
               end
               if (unvisited_ff == CW'(1)) begin
                  state_in = ST_FINISH;
               end
            end
         end
         default: begin
            if (out_free) begin
               load_out = 1'b1;
               count_in = kept_ff;
               state_in = ST_IDLE;
            end
         end
      endcase
   end

   assign rsp_valid_in = load_out || (rsp_valid_ff && !rsp_ready);
   assign req_ready    = (state_ff == ST_IDLE);

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_IDLE;
         step_ff       <= STEP_BEND;
         count_ff      <= '0;
         unvisited_ff  <= '0;
         kept_ff       <= '0;
         emitted_ff    <= '0;
         pend_valid_ff <= 1'b0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         state_ff      <= state_in;
         step_ff       <= step_in;
         count_ff      <= count_in;
         unvisited_ff  <= unvisited_in;
         kept_ff       <= kept_in;
         emitted_ff    <= emitted_in;
         pend_valid_ff <= pend_valid_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
   end

   // capture command fields
   always_ff @(posedge clock) begin
      if (accept) begin
         on_time_ff  <= req_note_on_time;
         off_time_ff <= req_note_off_time;
         chan_ff     <= chan_nib;
         note_ff     <= req_note;
         vel_ff      <= req_velocity;
         bend_ff     <= req_bend_value;
         hold_ff     <= req_bend_hold;
         start_ff    <= req_block_start;
         len_ff      <= req_block_length;
      end
   end

   // hold the latest match until the next one or the end of the walk
   always_ff @(posedge clock) begin
      if (load_pend) begin
         pend_ff     <= head;
         pend_off_ff <= head_off[OFFSET_W-1:0];
      end
   end

   // load the output register
   always_ff @(posedge clock) begin
      if (load_out) begin
         if (state_ff == ST_FINISH && !pend_valid_ff) begin
            out_ff     <= '0;
            out_off_ff <= '0;
            out_has_ff <= 1'b0;
         end else begin
            out_ff     <= pend_ff;
            out_off_ff <= pend_off_ff;
            out_has_ff <= 1'b1;
         end
         out_last_ff <= (state_ff == ST_FINISH);
      end
   end

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_status_byte   = out_ff.status;
   assign rsp_data_one      = out_ff.data_one;
   assign rsp_data_two      = out_ff.data_two;
   assign rsp_sample_offset = out_off_ff;
   assign rsp_has_event     = out_has_ff;
   assign rsp_last          = out_last_ff;

endmodule
`default_nettype wire

>>> dv/timed_midi_event_queue_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// timed_midi_event_queue_tb: self-checking bench for the timed MIDI queue
// Drives schedule, flush and clear commands with random gaps and receiver
// stalls, predicts every flush result from a local queue image and compares
// each response transfer field by field in order.
// ----------------------------------------------------------------------------
`default_nettype none

class flush_scoreboard;
   typedef struct packed {
      logic [7:0]  status;
      logic [6:0]  data_one;
      logic [6:0]  data_two;
      logic [15:0] offset;
      logic        has_event;
      logic        last;
   } flush_result_type;

   logic [47:0]      q_time[$];
   logic [23:0]      q_msg[$];
   flush_result_type pending[$];
   int               errors;
   int               depth;

   function new(int d);
      depth = d;
      errors = 0;
   endfunction

   function void append_msg(logic [47:0] t, logic [7:0] st, logic [6:0] d1, logic [6:0] d2);
      if (q_time.size() < depth) begin
         q_time.push_back(t);
         q_msg.push_back({st, 1'b0, d1, 1'b0, d2});
      end
   endfunction

   // apply one accepted command to the queue image
   function void note_command(logic [1:0] op, logic [47:0] on_t, logic [47:0] off_t,
                              logic [4:0] ch, logic [6:0] nt, logic [6:0] vel,
                              logic [13:0] bend, logic [15:0] hold,
                              logic [47:0] start, logic [15:0] len);
      logic [3:0]       nib;
      logic [47:0]      off;
      logic [47:0]      kt[$];
      logic [23:0]      km[$];
      flush_result_type r;
      int               n;
      nib = (ch == 0) ? 4'd0 : (ch > 16) ? 4'd15 : 4'(ch - 1);
      case (op)
         tmeq_pkg::OP_SCHEDULE: begin
            if (bend != tmeq_pkg::BEND_CENTRE) begin
               append_msg(on_t, {tmeq_pkg::STATUS_BEND, nib}, bend[6:0], bend[13:7]);
               append_msg(on_t + 48'(hold), {tmeq_pkg::STATUS_BEND, nib},
                          tmeq_pkg::BEND_CENTRE[6:0], tmeq_pkg::BEND_CENTRE[13:7]);
            end
            append_msg(on_t, {tmeq_pkg::STATUS_ON, nib}, nt, vel);
            append_msg(off_t, {tmeq_pkg::STATUS_OFF, nib}, nt, 7'd0);
         end
         tmeq_pkg::OP_FLUSH: begin
            n = 0;
            foreach (q_time[i]) begin
               off = q_time[i] - start;
               if (off < 48'(len) && n < tmeq_pkg::MAX_RESULTS) begin
                  r = '{q_msg[i][23:16], q_msg[i][14:8], q_msg[i][6:0], off[15:0], 1'b1, 1'b0};
                  pending.push_back(r);
                  n++;
               end else begin
                  kt.push_back(q_time[i]);
                  km.push_back(q_msg[i]);
               end
            end
            q_time = kt;
            q_msg = km;
            if (n == 0) pending.push_back('{8'd0, 7'd0, 7'd0, 16'd0, 1'b0, 1'b1});
            else pending[pending.size()-1].last = 1'b1;
         end
         tmeq_pkg::OP_CLEAR: begin
            q_time.delete();
            q_msg.delete();
         end
         default: ;
      endcase
   endfunction

   // compare one response transfer with the oldest expectation
   function void check_result(flush_result_type act);
      flush_result_type exp;
      if (pending.size() == 0) begin
         $display("%0t: unexpected result %h", $time, act);
         errors++;
         return;
      end
      exp = pending.pop_front();
      if (act.status !== exp.status)
         $display("%0t: status exp %h act %h", $time, exp.status, act.status);
      if (act.data_one !== exp.data_one)
         $display("%0t: data_one exp %h act %h", $time, exp.data_one, act.data_one);
      if (act.data_two !== exp.data_two)
         $display("%0t: data_two exp %h act %h", $time, exp.data_two, act.data_two);
      if (act.offset !== exp.offset)
         $display("%0t: offset exp %h act %h", $time, exp.offset, act.offset);
      if (act.has_event !== exp.has_event)
         $display("%0t: has_event exp %b act %b", $time, exp.has_event, act.has_event);
      if (act.last !== exp.last)
         $display("%0t: last exp %b act %b", $time, exp.last, act.last);
      if (act !== exp) errors++;
   endfunction
endclass

module timed_midi_event_queue_tb;
   import tmeq_pkg::*;

   localparam int         DEPTH       = 32;
   localparam int         STALL_LIMIT = 20000;
   localparam logic [1:0] OP_UNUSED   = 2'd3;

   logic                clock;
   logic                reset;
   logic                req_valid;
   logic                req_ready;
   logic [1:0]          req_opcode;
   logic [TIME_W-1:0]   req_note_on_time;
   logic [TIME_W-1:0]   req_note_off_time;
   logic [4:0]          req_channel;
   logic [6:0]          req_note;
   logic [6:0]          req_velocity;
   logic [13:0]         req_bend_value;
   logic [15:0]         req_bend_hold;
   logic [TIME_W-1:0]   req_block_start;
   logic [OFFSET_W-1:0] req_block_length;
   logic                rsp_valid;
   logic                rsp_ready;
   logic [7:0]          rsp_status_byte;
   logic [6:0]          rsp_data_one;
   logic [6:0]          rsp_data_two;
   logic [OFFSET_W-1:0] rsp_sample_offset;
   logic                rsp_has_event;
   logic                rsp_last;

   flush_scoreboard board;
   bit              calm;
   int              idle_cycles;

   timed_midi_event_queue #(.QUEUE_DEPTH(DEPTH)) u_dut (.*);

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // check every response transfer, stall the receiver in bursts
   initial begin
      int burst;
      rsp_ready = 1'b0;
      burst = 0;
      forever begin
         @(posedge clock);
         if (!reset && rsp_valid && rsp_ready)
            board.check_result({rsp_status_byte, rsp_data_one, rsp_data_two,
                                rsp_sample_offset, rsp_has_event, rsp_last});
         if (burst > 0) begin
            burst--;
            rsp_ready <= 1'b0;
         end else if (!calm && $urandom_range(0, 5) == 0) begin
            burst = $urandom_range(1, 16);
            rsp_ready <= 1'b0;
         end else begin
            rsp_ready <= 1'b1;
         end
      end
   end

   // end the run when nothing moves for too long
   always @(posedge clock) begin
      if (reset || (req_valid && req_ready) || (rsp_valid && rsp_ready)) idle_cycles <= 0;
      else idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= STALL_LIMIT) begin
         $display("CHECK FAILED");
         $finish;
      end
   end

   function automatic logic [47:0] rand_time();
      return {16'($urandom), $urandom};
   endfunction

   // hold one command until transfer, with an optional gap first
   task automatic send_cmd(logic [1:0] op, logic [47:0] on_t, logic [47:0] off_t,
                           logic [4:0] ch, logic [6:0] nt, logic [6:0] vel,
                           logic [13:0] bend, logic [15:0] hold,
                           logic [47:0] start, logic [15:0] len);
      if (!calm && $urandom_range(0, 4) == 0) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 16)) @(posedge clock);
      end
      req_valid         <= 1'b1;
      req_opcode        <= op;
      req_note_on_time  <= on_t;
      req_note_off_time <= off_t;
      req_channel       <= ch;
      req_note          <= nt;
      req_velocity      <= vel;
      req_bend_value    <= bend;
      req_bend_hold     <= hold;
      req_block_start   <= start;
      req_block_length  <= len;
      do @(posedge clock); while (!(req_valid && req_ready));
      board.note_command(op, on_t, off_t, ch, nt, vel, bend, hold, start, len);
   endtask

   task automatic schedule(logic [47:0] on_t, logic [47:0] off_t, logic [4:0] ch,
                           logic [6:0] nt, logic [6:0] vel, logic [13:0] bend,
                           logic [15:0] hold);
      send_cmd(OP_SCHEDULE, on_t, off_t, ch, nt, vel, bend, hold, rand_time(), 16'($urandom));
   endtask

   task automatic flush(logic [47:0] start, logic [15:0] len);
      send_cmd(OP_FLUSH, rand_time(), rand_time(), 5'($urandom), 7'($urandom),
               7'($urandom), 14'($urandom), 16'($urandom), start, len);
   endtask

   initial begin
      logic [47:0] base;
      logic [1:0]  noise;
      int          pick;
      board = new(DEPTH);
      calm = 1'b0;
      reset = 1'b1;
      req_valid = 1'b0;
      req_opcode = OP_CLEAR;
      req_note_on_time = '0;
      req_note_off_time = '0;
      req_channel = '0;
      req_note = '0;
      req_velocity = '0;
      req_bend_value = '0;
      req_bend_hold = '0;
      req_block_start = '0;
      req_block_length = '0;
      repeat (11) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // directed: empty flush, extremes, channel saturation, wrap, overflow
      flush(48'd0, 16'hFFFF);
      schedule(48'd0, 48'd10, 5'd1, 7'd0, 7'd127, BEND_CENTRE, 16'd0);
      schedule(48'd5, 48'd6, 5'd0, 7'd127, 7'd0, 14'd0, 16'hFFFF);
      schedule(48'hFFFF_FFFF_FFFF, 48'd3, 5'd31, 7'h55, 7'h2A, 14'h3FFF, 16'd4);
      schedule(48'd20, 48'd30, 5'd16, 7'h2A, 7'h55, 14'h1555, 16'd1);
      flush(48'd0, 16'd0);
      flush(48'hFFFF_FFFF_FFF0, 16'd32);
      flush(48'd0, 16'hFFFF);
      flush(48'hFFFF_FFFF_FFFF, 16'hFFFF);
      send_cmd(OP_UNUSED, '1, '1, '1, '1, '1, '1, '1, '1, '1);
      for (int i = 0; i < 10; i++)
         schedule(48'd100 + i, 48'd200, 5'(i + 1), 7'(i), 7'd64, 14'd100, 16'd2);
      flush(48'd100, 16'd200);
      flush(48'd100, 16'd200);
      schedule(48'd7, 48'd8, 5'd2, 7'd1, 7'd1, 14'd0, 16'd0);
      send_cmd(OP_CLEAR, '0, '0, '0, '0, '0, '0, '0, '0, '0);
      flush(48'd0, 16'hFFFF);

      // random: schedules clustered near a base time, windows over the cluster, occasional clear or unused commands
      for (int k = 0; k < 200; k++) begin
         if (k == 170) calm = 1'b1;
         if (k % 40 == 0) base = rand_time();
         pick = $urandom_range(0, 19);
         if (pick < 11) begin
            schedule(base + $urandom_range(0, 2000), base + $urandom_range(0, 4000),
                     5'($urandom), 7'($urandom), 7'($urandom),
                     ($urandom_range(0, 2) == 0) ? BEND_CENTRE : 14'($urandom),
                     ($urandom_range(0, 3) == 0) ? 16'($urandom) : 16'($urandom_range(0, 500)));
         end else if (pick < 18) begin
            flush(base + $urandom_range(0, 3000) - 48'd500,
                  ($urandom_range(0, 4) == 0) ? 16'($urandom) : 16'($urandom_range(0, 1500)));
         end else begin
            noise = ($urandom_range(0, 1) == 0) ? OP_CLEAR : OP_UNUSED;
            send_cmd(noise, rand_time(), rand_time(), 5'($urandom), 7'($urandom),
                     7'($urandom), 14'($urandom), 16'($urandom), rand_time(), 16'($urandom));
         end
      end
      req_valid <= 1'b0;

      while (board.pending.size() != 0) @(posedge clock);
      repeat (100) @(posedge clock);
      if (board.errors == 0) begin
         $display("CHECK OK");
      end else begin
         $display("CHECK FAILED");
      end
      $finish;
   end
endmodule

`default_nettype wire
